// ----- rtl/core/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU tag block.
// No dependencies; every other file imports this package.
package salc_pkg;

    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_BITS    = 32;

    localparam int SET_CFG_W  = 4;
    localparam int OFF_CFG_W  = 5;
    localparam int WAYS_CFG_W = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int OP_W       = 2;
    localparam int WAY_OUT_W  = 3;
    localparam int CNT_W      = 32;

    typedef enum logic [OP_W-1:0] {
        OP_IGNORE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STORE  = 2'd2,
        OP_MODIFY = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read_row;
        logic commit;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic slot_free;
    } dp_status_t;

endpackage

// ----- rtl/core/salc_ctrl.sv -----
// Sequencer for the LRU tag block: clearing pass, row read and commit steps.
// Depends on salc_pkg for the opcode codes and the command and status structs.
module salc_ctrl
    import salc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [OP_W-1:0]     opcode,
    output logic                in_ready,
    output ctrl_cmd_t           cmd,
    input  dp_status_t          status
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   two_left_reg;
    logic   two_left_next;

    always_comb
    begin
        state_next    = state_reg;
        two_left_next = two_left_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (opcode != OP_IGNORE))
                begin
                    cmd.capture   = 1'b1;
                    cmd.read_row  = 1'b1;
                    two_left_next = (opcode == OP_MODIFY);
                    state_next    = ST_LOOK;
                end
            end
            ST_READ:
            begin
                cmd.read_row = 1'b1;
                state_next   = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    cmd.last   = !two_left_reg;
                    if (two_left_reg)
                    begin
                        two_left_next = 1'b0;
                        state_next    = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            two_left_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            two_left_reg <= two_left_next;
        end
    end

endmodule

// ----- rtl/core/salc_dp.sv -----
// Datapath of the LRU tag block: configuration, address split, set row memory,
// tag compare, victim choice, age update, counters and the output register.
// Depends on salc_pkg; driven by salc_ctrl through the command struct.
module salc_dp
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ADDR_BITS-1:0]  address,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  hit,
    output logic                  evicted,
    output logic [WAY_OUT_W-1:0]  way_used,
    output logic [CNT_W-1:0]      hits_total,
    output logic [CNT_W-1:0]      misses_total,
    output logic [CNT_W-1:0]      evictions_total,
    output logic                  last
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int SHIFT_W  = OFF_CFG_W + 1;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    logic [SET_CFG_W-1:0]  set_cfg_reg;
    logic [OFF_CFG_W-1:0]  off_cfg_reg;
    logic [WAYS_CFG_W-1:0] ways_cfg_reg;

    logic [SET_CFG_W-1:0]  set_bits_eff;
    logic [SHIFT_W-1:0]    tag_shift;
    logic [ADDR_BITS-1:0]  set_shifted;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_in;
    logic [WCNT_W-1:0]     ways_eff;

    logic [ADDR_BITS-1:0]  tag_reg;
    logic [SET_W-1:0]      set_reg;
    logic [SET_W-1:0]      rd_addr;
    logic [SET_W-1:0]      clr_cnt_reg;

    logic [MAX_WAYS-1:0]                valid_mem [NUM_SETS];
    logic [MAX_WAYS-1:0][AGE_W-1:0]     age_mem   [NUM_SETS];
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem   [NUM_SETS];

    logic [MAX_WAYS-1:0]                row_valid_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0]     row_age_reg;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] row_tag_reg;

    logic                               lk_hit;
    logic                               lk_evict;
    logic [WAY_W-1:0]                   lk_way;
    logic [MAX_WAYS-1:0]                valid_new;
    logic [MAX_WAYS-1:0][AGE_W-1:0]     age_new;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_new;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic                  evicted_reg;
    logic [WAY_OUT_W-1:0]  way_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      hit_cnt_reg;
    logic [CNT_W-1:0]      miss_cnt_reg;
    logic [CNT_W-1:0]      evict_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_cfg_reg  <= '0;
            off_cfg_reg  <= '0;
            ways_cfg_reg <= WAYS_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:    set_cfg_reg  <= cfg_data[SET_CFG_W-1:0];
                CFG_OFFSET_BITS: off_cfg_reg  <= cfg_data[OFF_CFG_W-1:0];
                CFG_WAYS:        ways_cfg_reg <= cfg_data[WAYS_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A shift by the full address width or more yields zero, as required
    // for a wide offset or set split.
    always_comb
    begin
        if (int'(set_cfg_reg) > MAX_SET_BITS)
        begin
            set_bits_eff = SET_CFG_W'(MAX_SET_BITS);
        end
        else
        begin
            set_bits_eff = set_cfg_reg;
        end
        if (ways_cfg_reg == '0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if (int'(ways_cfg_reg) > MAX_WAYS)
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_cfg_reg);
        end
        tag_shift   = SHIFT_W'(set_bits_eff) + SHIFT_W'(off_cfg_reg);
        set_shifted = address >> off_cfg_reg;
        set_mask    = SET_W'((1 << set_bits_eff) - 1);
        set_in      = set_shifted[SET_W-1:0] & set_mask;
        rd_addr     = cmd.capture ? set_in : set_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_reg <= address >> tag_shift;
            set_reg <= set_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step && !status.clear_last)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            valid_mem[clr_cnt_reg] <= '0;
            age_mem[clr_cnt_reg]   <= '0;
        end
        else if (cmd.commit)
        begin
            valid_mem[set_reg] <= valid_new;
            age_mem[set_reg]   <= age_new;
        end
        if (cmd.commit)
        begin
            tag_mem[set_reg] <= tag_new;
        end
        if (cmd.read_row)
        begin
            row_valid_reg <= valid_mem[rd_addr];
            row_age_reg   <= age_mem[rd_addr];
            row_tag_reg   <= tag_mem[rd_addr];
        end
    end

    always_comb
    begin
        logic                found;
        logic                free_found;
        logic [WAY_W-1:0]    hit_way;
        logic [WAY_W-1:0]    free_way;
        logic [WAY_W-1:0]    victim;
        logic [AGE_W-1:0]    best;
        logic [AGE_W-1:0]    ref_age;
        logic                was_valid;
        found      = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < ways_eff)
            begin
                if (!found && row_valid_reg[i] && (row_tag_reg[i] == tag_reg))
                begin
                    found   = 1'b1;
                    hit_way = WAY_W'(i);
                end
                if (!free_found && !row_valid_reg[i])
                begin
                    free_found = 1'b1;
                    free_way   = WAY_W'(i);
                end
            end
        end
        best   = row_age_reg[0];
        victim = '0;
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if ((i < ways_eff) && (row_age_reg[i] > best))
            begin
                best   = row_age_reg[i];
                victim = WAY_W'(i);
            end
        end
        lk_hit   = found;
        lk_evict = !found && !free_found;
        if (found)
        begin
            lk_way = hit_way;
        end
        else if (free_found)
        begin
            lk_way = free_way;
        end
        else
        begin
            lk_way = victim;
        end
        was_valid = found || !free_found;
        ref_age   = row_age_reg[lk_way];
        valid_new = row_valid_reg;
        age_new   = row_age_reg;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if ((i < ways_eff) && (WAY_W'(i) != lk_way) && row_valid_reg[i]
                && (!was_valid || (row_age_reg[i] < ref_age))
                && (row_age_reg[i] != AGE_MAX))
            begin
                age_new[i] = row_age_reg[i] + AGE_W'(1);
            end
        end
        valid_new[lk_way] = 1'b1;
        age_new[lk_way]   = '0;
        tag_new           = row_tag_reg;
        tag_new[lk_way]   = tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (lk_hit)
                begin
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                end
                if (lk_evict)
                begin
                    evict_cnt_reg <= evict_cnt_reg + CNT_W'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg     <= lk_hit;
            evicted_reg <= lk_evict;
            way_reg     <= WAY_OUT_W'(lk_way);
            last_reg    <= cmd.last;
        end
    end

    assign status.clear_last = (clr_cnt_reg == SET_W'(NUM_SETS - 1));
    assign status.slot_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign evicted         = evicted_reg;
    assign way_used        = way_reg;
    assign last            = last_reg;
    assign hits_total      = hit_cnt_reg;
    assign misses_total    = miss_cnt_reg;
    assign evictions_total = evict_cnt_reg;

endmodule

// ----- rtl/core/set_assoc_lru_cache_tags.sv -----
// Top level of the set-associative cache tag block with true LRU replacement.
// Depends on salc_pkg, salc_ctrl and salc_dp.
//
//   Channel   Handshake              Contents
//   in        in_valid / in_ready    opcode, address
//   out       out_valid / out_ready  hit, evicted, way_used, totals, last
//   cfg       cfg_we                 cfg_index, cfg_data
//
// A load or store is one read of the set row followed by one write-back of
// that row; a modify is two such pairs, and an ignore is taken with neither.
// After reset a clearing pass over all 2**MAX_SET_BITS sets (256 by default)
// zeroes the valid and age bits; no word is accepted until it ends.
// A result waits in the output register while the next word is accepted; the
// block stalls a write-back only if that register is full and out_ready low.
module set_assoc_lru_cache_tags
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       opcode,
    input  logic [ADDR_BITS-1:0]  address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic                  evicted,
    output logic [WAY_OUT_W-1:0]  way_used,
    output logic [CNT_W-1:0]      hits_total,
    output logic [CNT_W-1:0]      misses_total,
    output logic [CNT_W-1:0]      evictions_total,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    salc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .address         (address),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .hit             (hit),
        .evicted         (evicted),
        .way_used        (way_used),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total),
        .last            (last)
    );

endmodule

// ----- rtl/core/salc_checker.sv -----
// Port-level checks for the LRU tag block, bound to its top level.
// Depends on salc_pkg and on set_assoc_lru_cache_tags.
module salc_checker
    import salc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 hit,
    input logic                 evicted,
    input logic [WAY_OUT_W-1:0] way_used,
    input logic [CNT_W-1:0]     hits_total,
    input logic [CNT_W-1:0]     misses_total,
    input logic                 last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(way_used)
            && $stable(last))
        else $error("stalled result word changed");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted)
        else $error("hit reported together with an eviction");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) ##1 out_valid
            |-> CNT_W'(hits_total + misses_total)
                == CNT_W'($past(hits_total + misses_total) + CNT_W'(1)))
        else $error("access count did not advance by one between words");

    a_modify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("new word accepted before the second half of a modify");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (.*);
